[rtl/core/hlgs_pkg.sv]
// Package: shared types and constants for the HighLife generation stencil.
package hlgs_pkg;

    localparam int MAX_SIZE = 128;
    localparam int ADDR_W   = $clog2(MAX_SIZE);

    localparam logic [7:0] GRID_RESET = 8'd80;
    localparam logic [7:0] GRID_MIN   = 8'd3;
    localparam logic [7:0] GRID_MAX   = 8'(MAX_SIZE);

    localparam logic [3:0] SURVIVE_A = 4'd2;
    localparam logic [3:0] SURVIVE_B = 4'd3;
    localparam logic [3:0] BIRTH_A   = 4'd3;
    localparam logic [3:0] BIRTH_B   = 4'd6;

    typedef enum logic {
        KIND_CELL  = 1'b0,
        KIND_FLUSH = 1'b1
    } t_kind;

    typedef struct packed {
        logic kind;
        logic alive;
    } t_in_item;

    typedef struct packed {
        logic       next_alive;
        logic [6:0] cell_row;
        logic [6:0] cell_col;
        logic       frame_last;
    } t_out_item;

    // One row-store entry: the two rows above the incoming cell.
    typedef struct packed {
        logic older;
        logic newer;
    } t_row_pair;

endpackage

[rtl/core/hlgs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
module hlgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/highlife_generation_stencil.sv]
// Top level: HighLife (B36/S23) one-generation stencil over a raster cell stream.
// Results go to the output register, or to the skid stage while the output is held.
// Throughput: one input item per cycle while the skid is empty; the row-store RAM read
//   is prefetched at the next column, so a cell sees its column's two upper rows at once.
// Reset (synchronous, active low) sets grid_size to 80 and clears stream state and
//   the output buffer; the row store is not cleared, rows above the top are masked.
module highlife_generation_stencil (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hlgs_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hlgs_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    import hlgs_pkg::*;

    // Stream state
    logic [7:0]        r_grid_size, n_grid_size;
    logic [8:0]        r_window,    n_window;
    logic [6:0]        r_in_row,    n_in_row;
    logic [6:0]        r_in_col,    n_in_col;
    logic [6:0]        r_out_row,   n_out_row;
    logic [6:0]        r_out_col,   n_out_col;
    logic [7:0]        r_pending,   n_pending;

    // Output register plus skid stage
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data,  n_out_data;
    logic              r_skid_valid, n_skid_valid;
    t_out_item         r_skid_data,  n_skid_data;

    // Row store
    logic              ram_wr_en;
    t_row_pair         ram_wr_data;
    t_row_pair         ram_rd_data;

    // Per-item datapath
    logic              in_acc;
    logic [7:0]        side;
    logic [2:0]        column;
    logic              first_col;
    logic [8:0]        win_shift;
    logic [3:0]        count;
    logic              next_state;
    logic              res_valid;
    t_out_item         res_data;
    logic [7:0]        col_inc;
    logic [7:0]        row_inc;
    logic [7:0]        ocol_inc;
    logic              out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign in_acc      = i_in_valid && o_in_ready;

    // Side length clamped to the supported range
    always_comb begin
        side = r_grid_size;
        if (side < GRID_MIN) side = GRID_MIN;
        if (side > GRID_MAX) side = GRID_MAX;
    end

    // Read port always looks at the next input column, so data is ready on arrival.
    hlgs_ram #(
        .WIDTH ($bits(t_row_pair)),
        .DEPTH (MAX_SIZE)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_in_col[ADDR_W-1:0]),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (n_in_col[ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Window: three columns of 3 bits, newest in [8:6]; inside a column
    // bit 0 is the upper row, bit 2 the lower.
    always_comb begin
        if (i_in_data.kind == KIND_CELL) begin
            column[0] = (r_in_row >= 7'd2) ? ram_rd_data.older : 1'b0;
            column[1] = (r_in_row >= 7'd1) ? ram_rd_data.newer : 1'b0;
            column[2] = i_in_data.alive;
        end else begin
            column[0] = ram_rd_data.older;
            column[1] = ram_rd_data.newer;
            column[2] = 1'b0;
        end
        first_col = (r_in_col == 7'd0);
        win_shift = {(first_col ? 3'b000 : column), r_window[8:3]};

        count = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) count = count + 4'(win_shift[i]);
        end
        if (win_shift[4]) next_state = (count == SURVIVE_A) || (count == SURVIVE_B);
        else              next_state = (count == BIRTH_A)   || (count == BIRTH_B);
    end

    assign col_inc  = {1'b0, r_in_col}  + 8'd1;
    assign row_inc  = {1'b0, r_in_row}  + 8'd1;
    assign ocol_inc = {1'b0, r_out_col} + 8'd1;

    // Stream control and result forming
    always_comb begin
        n_grid_size = r_grid_size;
        n_window    = r_window;
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_pending   = r_pending;
        ram_wr_en   = 1'b0;
        ram_wr_data = '{older: ram_rd_data.newer, newer: i_in_data.alive};
        res_valid   = 1'b0;
        res_data    = '{next_alive: next_state, cell_row: r_out_row,
                        cell_col: r_out_col, frame_last: 1'b0};

        if (i_cfg_valid) begin
            // new size restarts the frame
            n_grid_size = i_cfg_data;
            n_window    = '0;
            n_in_row    = '0;
            n_in_col    = '0;
            n_out_row   = '0;
            n_out_col   = '0;
            n_pending   = '0;
        end else if (in_acc) begin
            if (i_in_data.kind == KIND_CELL) begin
                if (r_pending == 8'd0) begin
                    ram_wr_en = 1'b1;
                    n_window  = first_col ? {column, 6'b0} : win_shift;
                    res_valid = (r_in_row >= 7'd2) ||
                                ((r_in_row == 7'd1) && (r_in_col >= 7'd1));
                    if (col_inc >= side) begin
                        n_in_col = '0;
                        if (row_inc >= side) begin
                            // last cell of the frame: drain with side+1 flushes
                            n_in_row  = '0;
                            n_pending = side + 8'd1;
                        end else begin
                            n_in_row = row_inc[6:0];
                        end
                    end else begin
                        n_in_col = col_inc[6:0];
                    end
                end
            end else if (r_pending != 8'd0) begin
                n_window  = first_col ? {column, 6'b0} : win_shift;
                n_in_col  = (col_inc >= side) ? 7'd0 : col_inc[6:0];
                n_pending = r_pending - 8'd1;
                res_valid = 1'b1;
                if (r_pending == 8'd1) begin
                    res_data.frame_last = 1'b1;
                end
            end

            if (res_valid) begin
                if (ocol_inc >= side) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 7'd1;
                end else begin
                    n_out_col = ocol_inc[6:0];
                end
            end

            if (res_valid && res_data.frame_last) begin
                n_window  = '0;
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
                n_pending = '0;
            end
        end
    end

    // Output register with skid: input is taken while a result waits.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out_data  = res_data;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid_data  = res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size  <= GRID_RESET;
            r_window     <= '0;
            r_in_row     <= '0;
            r_in_col     <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_pending    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_grid_size  <= n_grid_size;
            r_window     <= n_window;
            r_in_row     <= n_in_row;
            r_in_col     <= n_in_col;
            r_out_row    <= n_out_row;
            r_out_col    <= n_out_col;
            r_pending    <= n_pending;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[bench/highlife_generation_stencil_test.sv]
// Self-checking bench for the HighLife generation stencil: directed table, then random frames.
`timescale 1ns / 100ps

module highlife_generation_stencil_test;
    import hlgs_pkg::*;

    localparam int ITEMS    = 1100;  // random cell and flush items to offer
    localparam int LIMIT    = 3000;  // cycles without any handshake before giving up
    localparam int SETTLE   = 4;     // settling margin after the last expected result
    localparam int HOLD_AT  = 200;   // result count that arms the long sink hold-off
    localparam int HOLD_LEN = 150;
    localparam int BUSY_LO  = 400;   // no idling on either side inside this item window
    localparam int BUSY_HI  = 600;

    typedef enum logic [1:0] {
        OP_CELL,
        OP_FLUSH,
        OP_CFG
    } t_dir_op;

    // How a directed row's result is judged: by the predictor, as "no result",
    // or against a value typed into the table.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_FIXED
    } t_chk;

    typedef struct packed {
        t_dir_op    op;
        logic [7:0] val;     // grid size for OP_CFG, alive in bit 0 for cells
        t_chk       chk;
        t_out_item  fixed;
    } t_dir_row;

    localparam t_out_item NO_RES = '0;
    localparam int DIR_LEN = 26;

    // Directed part. The 3x3 all-alive frame keeps only its corners: each corner
    // sees exactly three live neighbours.
    localparam t_dir_row DIR_TABLE [0:DIR_LEN-1] = '{
        '{OP_FLUSH, 8'd0,   CHK_NONE,  NO_RES},  // reset state, nothing pending
        '{OP_CFG,   8'd3,   CHK_NONE,  NO_RES},  // smallest grid
        '{OP_FLUSH, 8'd0,   CHK_NONE,  NO_RES},  // stray flush at frame start
        '{OP_CELL,  8'd1,   CHK_NONE,  NO_RES},  // first n+1 cells give nothing
        '{OP_CELL,  8'd1,   CHK_NONE,  NO_RES},
        '{OP_CELL,  8'd1,   CHK_NONE,  NO_RES},
        '{OP_CELL,  8'd1,   CHK_NONE,  NO_RES},
        '{OP_CELL,  8'd1,   CHK_FIXED, t_out_item'{1'b1, 7'd0, 7'd0, 1'b0}},
        '{OP_CELL,  8'd1,   CHK_MODEL, NO_RES},
        '{OP_CELL,  8'd1,   CHK_MODEL, NO_RES},
        '{OP_CELL,  8'd1,   CHK_MODEL, NO_RES},
        '{OP_CELL,  8'd1,   CHK_MODEL, NO_RES},
        '{OP_FLUSH, 8'd0,   CHK_MODEL, NO_RES},
        '{OP_CELL,  8'd0,   CHK_NONE,  NO_RES},  // cell while flush results pending
        '{OP_FLUSH, 8'd0,   CHK_MODEL, NO_RES},
        '{OP_FLUSH, 8'd0,   CHK_MODEL, NO_RES},
        '{OP_FLUSH, 8'd0,   CHK_FIXED, t_out_item'{1'b1, 7'd2, 7'd2, 1'b1}},
        '{OP_CFG,   8'd0,   CHK_NONE,  NO_RES},  // below range, clamps to 3
        '{OP_CELL,  8'd0,   CHK_NONE,  NO_RES},
        '{OP_CELL,  8'd1,   CHK_NONE,  NO_RES},
        '{OP_CELL,  8'd1,   CHK_NONE,  NO_RES},
        '{OP_CELL,  8'd0,   CHK_NONE,  NO_RES},
        '{OP_CELL,  8'd1,   CHK_MODEL, NO_RES},
        '{OP_CFG,   8'd255, CHK_NONE,  NO_RES},  // above range mid-frame, clamps to 128
        '{OP_CELL,  8'd1,   CHK_NONE,  NO_RES},
        '{OP_CELL,  8'd0,   CHK_NONE,  NO_RES}
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = '0;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_data;
    logic       cfg_ready;

    // Predictor copy of the block state.
    logic [7:0]  grid_reg;
    bit          older_rs [MAX_SIZE];
    bit          newer_rs [MAX_SIZE];
    bit [8:0]    nwin;
    int unsigned in_row, in_col, out_row, out_col, pend;

    t_out_item next_gen_q [$];   // next-generation results still to come out
    t_out_item want;
    int        mismatches    = 0;
    int        results_taken = 0;
    int        items_sent    = 0;
    int        hold_left     = 0;
    int        idle_stall    = 0;
    bit        paused_once   = 1'b0;
    bit        held_once     = 1'b0;

    highlife_generation_stencil dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Side of the grid in use: the register clamped to the legal range.
    function automatic int unsigned side_of(input logic [7:0] v);
        if (v < GRID_MIN) return int'(GRID_MIN);
        if (v > GRID_MAX) return MAX_SIZE;
        return int'(v);
    endfunction

    function void rewind_frame();
        nwin    = '0;
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
        pend    = 0;
    endfunction

    // Shift a new column (bit 0 upper, 1 middle, 2 lower) into the 3x3 window
    // and return the next state of the centre cell. A first column starts a
    // fresh row, so the left neighbours are dead.
    function automatic bit shift_window(input bit [2:0] column, input bit first_col);
        bit [8:0]    w;
        int unsigned cnt;
        bit          nx;
        w   = {first_col ? 3'b000 : column, nwin[8:3]};
        cnt = $countones(w & 9'h1EF);
        if (w[4]) nx = (cnt == SURVIVE_A) || (cnt == SURVIVE_B);
        else      nx = (cnt == BIRTH_A) || (cnt == BIRTH_B);
        nwin = first_col ? {column, 6'b000000} : w;
        return nx;
    endfunction

    function automatic void emit_next(output t_out_item r, input bit nx, input bit last,
                                      input int unsigned n);
        r.next_alive = nx;
        r.cell_row   = 7'(out_row);
        r.cell_col   = 7'(out_col);
        r.frame_last = last;
        out_col++;
        if (out_col >= n) begin
            out_col = 0;
            out_row++;
        end
    endfunction

    // Advance the predictor by one accepted item; returns 1 when a result is due.
    function automatic bit highlife_predict(input t_in_item it, output t_out_item r);
        int unsigned n, ic;
        bit          top, mid, nx, ok;
        r  = NO_RES;
        n  = side_of(grid_reg);
        ic = (in_col >= n) ? 0 : in_col;
        if (it.kind == KIND_CELL) begin
            if (pend != 0) return 1'b0;
            // rows above the top of the grid are dead, whatever the store holds
            top = (in_row >= 2) ? older_rs[ic] : 1'b0;
            mid = (in_row >= 1) ? newer_rs[ic] : 1'b0;
            older_rs[ic] = newer_rs[ic];
            newer_rs[ic] = it.alive;
            ok = (in_row >= 2) || (in_row == 1 && ic >= 1);
            nx = shift_window({it.alive, mid, top}, ic == 0);
            ic++;
            if (ic >= n) begin
                ic = 0;
                in_row++;
            end
            in_col = ic;
            if (in_row >= n) begin
                in_row = 0;
                in_col = 0;
                pend   = n + 1;
            end
            if (!ok) return 1'b0;
            emit_next(r, nx, 1'b0, n);
            return 1'b1;
        end
        if (pend == 0) return 1'b0;
        // below the bottom row everything is dead
        nx = shift_window({1'b0, newer_rs[ic], older_rs[ic]}, ic == 0);
        ic++;
        if (ic >= n) ic = 0;
        in_col = ic;
        pend--;
        emit_next(r, nx, pend == 0, n);
        if (pend == 0) rewind_frame();
        return 1'b1;
    endfunction

    function bit take_break();
        if (items_sent >= BUSY_LO && items_sent < BUSY_HI) return 1'b0;
        return $urandom_range(99) < 16;
    endfunction

    // Offer one item, wait for its handshake, then record what it should cause.
    task automatic offer(input t_in_item it, input t_chk chk, input t_out_item fixed);
        t_out_item r;
        bit        has;
        while (take_break()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        has = highlife_predict(it, r);
        case (chk)
            CHK_MODEL: begin
                if (has) next_gen_q.push_back(r);
            end
            CHK_FIXED: begin
                next_gen_q.push_back(fixed);
            end
            default: begin
            end
        endcase
    endtask

    // Stop offering until every expected result is out, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (next_gen_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Grid size writes only happen with the block idle.
    task automatic write_grid(input logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        grid_reg = v;
        rewind_frame();
    endtask

    // One frame of random cells; a full frame is followed by its n+1 flushes.
    // Stray flushes mid-frame and stray cells among the flushes are ignored
    // by the block and are not counted.
    task automatic run_frame(input int n, input int cells);
        int density;
        density = 15 * $urandom_range(1, 4);
        for (int k = 0; k < cells; k++) begin
            if ($urandom_range(99) < 3)
                offer(t_in_item'{kind: KIND_FLUSH, alive: 1'($urandom_range(1))},
                      CHK_MODEL, NO_RES);
            // once, hold the sender back mid-frame until the results catch up
            if (!paused_once && cells > 20 && k == cells / 2) begin
                drain();
                paused_once = 1'b1;
            end
            offer(t_in_item'{kind: KIND_CELL, alive: ($urandom_range(99) < density)},
                  CHK_MODEL, NO_RES);
            items_sent++;
        end
        if (cells == n * n) begin
            for (int k = 0; k <= n; k++) begin
                if ($urandom_range(99) < 8)
                    offer(t_in_item'{kind: KIND_CELL, alive: 1'($urandom_range(1))},
                          CHK_MODEL, NO_RES);
                offer(t_in_item'{kind: KIND_FLUSH, alive: 1'($urandom_range(1))},
                      CHK_MODEL, NO_RES);
                items_sent++;
            end
        end
    endtask

    // Result sink: compare against the oldest expectation, then pick next ready.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (next_gen_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: alive %0d row %0d col %0d last %0d",
                             out_data.next_alive, out_data.cell_row, out_data.cell_col,
                             out_data.frame_last);
            end else begin
                want = next_gen_q.pop_front();
                if (out_data.next_alive !== want.next_alive ||
                    out_data.cell_row !== want.cell_row ||
                    out_data.cell_col !== want.cell_col ||
                    out_data.frame_last !== want.frame_last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("result mismatch (exp/got): alive %0d/%0d row %0d/%0d",
                               want.next_alive, out_data.next_alive,
                               want.cell_row, out_data.cell_row);
                        $display(" col %0d/%0d last %0d/%0d",
                                 want.cell_col, out_data.cell_col,
                                 want.frame_last, out_data.frame_last);
                    end
                end
            end
            results_taken++;
            // one long hold-off while the sender is busy, so the block fills up
            // and stalls its input
            if (!held_once && results_taken >= HOLD_AT && in_valid) begin
                hold_left = HOLD_LEN;
                held_once = 1'b1;
            end
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= rst_n && !take_break();
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_stall = 0;
        else
            idle_stall++;
        if (idle_stall >= LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int         pick, n, frames, cells;
        logic [7:0] v;
        t_dir_row   row;

        grid_reg = GRID_RESET;
        foreach (older_rs[i]) begin
            older_rs[i] = 1'b0;
            newer_rs[i] = 1'b0;
        end
        rewind_frame();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_LEN; i++) begin
            row = DIR_TABLE[i];
            if (row.op == OP_CFG)
                write_grid(row.val);
            else
                offer(t_in_item'{kind: (row.op == OP_FLUSH) ? KIND_FLUSH : KIND_CELL,
                                 alive: row.val[0]},
                      row.chk, row.fixed);
        end

        // Random phases: mostly grids of side up to 16 run as whole frames, now and then a
        // larger or full-size grid run as a short partial frame.
        while (items_sent < ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60)      v = 8'($urandom_range(3, 8));
            else if (pick < 80) v = 8'($urandom_range(9, 16));
            else if (pick < 86) v = 8'($urandom_range(0, 2));
            else if (pick < 90) v = GRID_MIN;
            else if (pick < 94) v = 8'($urandom_range(129, 255));
            else if (pick < 97) v = GRID_MAX;
            else                v = 8'($urandom_range(17, 127));
            write_grid(v);
            n = side_of(v);
            if (n > 16) begin
                run_frame(n, $urandom_range(140, 300));
            end else begin
                frames = $urandom_range(1, 2);
                for (int f = 0; f < frames; f++) begin
                    cells = n * n;
                    // the odd broken frame, cut short before its flushes
                    if (f == frames - 1 && $urandom_range(9) == 0)
                        cells = $urandom_range(1, n * n - 1);
                    run_frame(n, cells);
                end
            end
        end

        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
